@@ sv/crd_pkg.sv @@
// ============================================================================
// crd_pkg
// Shared types, constants and the byte-wide CRC-32 step for the record decoder.
// ============================================================================
`default_nettype none

package crd_pkg;

    localparam int RECORD_BYTES    = 56;
    localparam int CHECKSUM_OFFSET = 52;
    localparam int POS_SATURATE    = 57;
    localparam int POS_W           = 6;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] MAX_STATE_RESET = 8'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_CRC   = 3'd2,
        ST_BAD_ID    = 3'd3,
        ST_BAD_STATE = 3'd4,
        ST_FLAGS     = 3'd5,
        ST_NONFINITE = 3'd6
    } status_t;

    // byte k of the record sits in element k (little-endian when flattened)
    typedef logic [RECORD_BYTES-1:0][7:0] record_t;

    typedef struct packed {
        status_t pre_status;
        record_t record;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] card_id;
        logic [7:0]  card_state;
        logic [7:0]  review_step;
        logic [15:0] flag_bits;
        logic [63:0] due_time_ms;
        logic [63:0] last_review_ms;
        logic [31:0] stability_bits;
        logic [31:0] difficulty_bits;
        logic [31:0] repetitions;
        logic [31:0] lapse_count;
        logic [63:0] log_offset;
    } result_t;

    // queue handshake between front, queue and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/crd_in_if.sv @@
// ============================================================================
// crd_in_if
// Byte stream channel: one record byte and its last marker per transaction.
// ============================================================================
`default_nettype none

interface crd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/crd_out_if.sv @@
// ============================================================================
// crd_out_if
// Result channel: status and unpacked record fields, one record per transaction.
// ============================================================================
`default_nettype none

interface crd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [63:0] card_id;
    logic [7:0]         card_state;
    logic [7:0]         review_step;
    logic [15:0]        flag_bits;
    logic signed [63:0] due_time_ms;
    logic signed [63:0] last_review_ms;
    logic [31:0]        stability_bits;
    logic [31:0]        difficulty_bits;
    logic [31:0]        repetitions;
    logic [31:0]        lapse_count;
    logic [63:0]        log_offset;

    modport source (
        output valid, input ready,
        output status, output card_id, output card_state, output review_step,
        output flag_bits, output due_time_ms, output last_review_ms,
        output stability_bits, output difficulty_bits, output repetitions,
        output lapse_count, output log_offset
    );
    modport sink (
        input valid, output ready,
        input status, input card_id, input card_state, input review_step,
        input flag_bits, input due_time_ms, input last_review_ms,
        input stability_bits, input difficulty_bits, input repetitions,
        input lapse_count, input log_offset
    );
endinterface

`default_nettype wire

@@ sv/crd_front.sv @@
// ============================================================================
// crd_front
// Byte intake: position count, running CRC, record shift line, length and
// checksum classification; pushes one entry per closed record.
// ============================================================================
`default_nettype none

module crd_front
    import crd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    crd_in_if.sink       byte_in,
    input  wire q_stat_t q_stat,
    output logic         push,
    output entry_t       push_entry
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    record_t          rec_reg;
    record_t          rec_shift;
    logic             accept;
    logic [31:0]      stored_crc;
    status_t          len_crc_status;

    assign byte_in.ready = !q_stat.full;
    assign accept        = byte_in.valid && byte_in.ready;

    // shift line: after 56 shifts byte k sits in element k
    assign rec_shift = {byte_in.data_byte, rec_reg[RECORD_BYTES-1:1]};

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (pos_reg < POS_W'(CHECKSUM_OFFSET))
        begin
            crc_next = crc_byte(crc_reg, byte_in.data_byte);
        end
        if (pos_reg < POS_W'(POS_SATURATE))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (byte_in.last_byte)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < POS_W'(RECORD_BYTES)))
        begin
            rec_reg <= rec_shift;
        end
    end

    // stored checksum word, bytes 52..55; meaningful only at full length
    assign stored_crc = rec_shift[CHECKSUM_OFFSET+3:CHECKSUM_OFFSET];

    assign push       = accept && byte_in.last_byte;
    assign push_entry = {len_crc_status, rec_shift};

    always_comb
    begin
        if (pos_reg != POS_W'(RECORD_BYTES - 1))
        begin
            len_crc_status = ST_BAD_LEN;
        end
        else if (stored_crc != ~crc_reg)
        begin
            len_crc_status = ST_BAD_CRC;
        end
        else
        begin
            len_crc_status = ST_OK;
        end
    end

endmodule

`default_nettype wire

@@ sv/crd_queue.sv @@
// ============================================================================
// crd_queue
// Small FIFO of closed records between intake and field checking.
// ============================================================================
`default_nettype none

module crd_queue
    import crd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output q_stat_t     q_stat,
    output entry_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/crd_back.sv @@
// ============================================================================
// crd_back
// Field checks and unpacking of a queued record into the result register.
// ============================================================================
`default_nettype none

module crd_back
    import crd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] max_state,
    input  wire q_stat_t    q_stat,
    input  wire entry_t     head,
    output logic            pop,
    crd_out_if.source       result_out
);

    logic        out_valid_reg;
    result_t     res_reg, res_next;
    record_t     rec;
    logic [63:0] id;
    logic [7:0]  st;
    logic [15:0] fl;
    logic [31:0] stab, diff;
    status_t     status;

    assign rec  = head.record;
    assign id   = rec[7:0];
    assign st   = rec[8];
    assign fl   = rec[11:10];
    assign stab = rec[31:28];
    assign diff = rec[35:32];

    always_comb
    begin
        if (head.pre_status != ST_OK)
        begin
            status = head.pre_status;
        end
        else if ((id == 64'd0) || id[63])
        begin
            status = ST_BAD_ID;
        end
        else if (st > max_state)
        begin
            status = ST_BAD_STATE;
        end
        else if (fl != 16'd0)
        begin
            status = ST_FLAGS;
        end
        else if ((stab[30:23] == 8'hFF) || (diff[30:23] == 8'hFF))
        begin
            status = ST_NONFINITE;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        res_next        = '0;
        res_next.status = status;
        if (status == ST_OK)
        begin
            res_next.card_id         = id;
            res_next.card_state      = st;
            res_next.review_step     = rec[9];
            res_next.flag_bits       = fl;
            res_next.due_time_ms     = rec[19:12];
            res_next.last_review_ms  = rec[27:20];
            res_next.stability_bits  = stab;
            res_next.difficulty_bits = diff;
            res_next.repetitions     = rec[39:36];
            res_next.lapse_count     = rec[43:40];
            res_next.log_offset      = rec[51:44];
        end
    end

    assign pop = q_stat.valid && (!out_valid_reg || result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            out_valid_reg <= q_stat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.status          = res_reg.status;
    assign result_out.card_id         = $signed(res_reg.card_id);
    assign result_out.card_state      = res_reg.card_state;
    assign result_out.review_step     = res_reg.review_step;
    assign result_out.flag_bits       = res_reg.flag_bits;
    assign result_out.due_time_ms     = $signed(res_reg.due_time_ms);
    assign result_out.last_review_ms  = $signed(res_reg.last_review_ms);
    assign result_out.stability_bits  = res_reg.stability_bits;
    assign result_out.difficulty_bits = res_reg.difficulty_bits;
    assign result_out.repetitions     = res_reg.repetitions;
    assign result_out.lapse_count     = res_reg.lapse_count;
    assign result_out.log_offset      = res_reg.log_offset;

endmodule

`default_nettype wire

@@ sv/checked_record_decoder.sv @@
// The record of the last byte goes into the FIFO, then into the output register.
// Throughput: one byte per cycle while the FIFO is not full; one result per record.
// The record FIFO (QUEUE_DEPTH entries) lets intake run on while results stall.
// Reset (rst_n, async, active low): position and CRC cleared, FIFO empty,
// result valid low, max_state back to 3. The record bytes are not cleared.
// ============================================================================
// checked_record_decoder
// CRC-32 checked 56-byte record decoder with status and field unpacking.
// ============================================================================
`default_nettype none

module checked_record_decoder
    import crd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    crd_in_if.sink          byte_in,
    crd_out_if.source       result_out
);

    // max_state register: largest state code that passes the check
    logic [7:0] max_state_reg;

    // front -> queue -> back
    logic    push;
    entry_t  push_entry;
    logic    pop;
    q_stat_t q_stat;
    entry_t  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_state_reg <= MAX_STATE_RESET;
        end
        else if (cfg_we)
        begin
            max_state_reg <= cfg_wdata;
        end
    end

    // Front: a byte advances the saturating position, folds bytes 0..51 into the CRC
    // and shifts bytes 0..55 into the line. The last byte closes the record; length
    // and CRC are judged right there and the whole record is queued with that verdict.
    crd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue holds full record copies, so the shift line is free to take
    // the next record while an earlier result waits downstream.
    crd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_stat     (q_stat),
        .head       (head)
    );

    // Back: id/state/flags/float checks in priority order, fields zeroed on
    // any failure, result held in the output register until taken.
    crd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_state  (max_state_reg),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

@@ sv/crd_checker.sv @@
// ============================================================================
// crd_checker
// Port-level checks on the result channel of the record decoder.
// ============================================================================
`default_nettype none

module crd_checker
    import crd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [63:0] card_id,
    input wire logic [7:0]  card_state,
    input wire logic [15:0] flag_bits,
    input wire logic [31:0] stability_bits,
    input wire logic [31:0] difficulty_bits,
    input wire logic [63:0] log_offset
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(card_id))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NONFINITE)
        else $error("status code out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (card_id == 64'd0) && (card_state == 8'd0) && (flag_bits == 16'd0)
            && (log_offset == 64'd0))
        else $error("fields not cleared on failing status");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            !card_id[63] && (card_id != 64'd0) && (flag_bits == 16'd0)
            && (stability_bits[30:23] != 8'hFF) && (difficulty_bits[30:23] != 8'hFF))
        else $error("ok status with failing fields");

endmodule

bind checked_record_decoder crd_checker u_crd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .status          (result_out.status),
    .card_id         (result_out.card_id),
    .card_state      (result_out.card_state),
    .flag_bits       (result_out.flag_bits),
    .stability_bits  (result_out.stability_bits),
    .difficulty_bits (result_out.difficulty_bits),
    .log_offset      (result_out.log_offset)
);

`default_nettype wire
